// ===== design/rfse_pkg.sv =====
// Shared constants, codes and types for the row FIR with mirrored edges
package rfse_pkg;

  localparam int unsigned MAX_WIDTH      = 2048;
  localparam int unsigned COL_BITS       = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_BITS       = COL_BITS + 1;
  localparam int unsigned MAX_TAPS       = 16;
  localparam int unsigned TAP_BITS       = $clog2(MAX_TAPS);
  localparam int unsigned TCNT_BITS      = 5;
  localparam int unsigned ROW_WIDTH_BITS = 12;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_BITS      = 16;
  localparam int unsigned COEF_SLOT      = 16;
  localparam int unsigned COEF_WORDS     = 4;
  localparam int unsigned WORD_SEL_BITS  = 2;
  localparam int unsigned PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_BITS       = 36;
  localparam int unsigned MAX_RESULTS    = 9;
  localparam int unsigned RES_BITS       = 4;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 64;
  localparam int unsigned IN_TDATA_BITS  = 16;
  localparam int unsigned OUT_TDATA_BITS = 48;
  localparam int unsigned OUT_PAD_BITS   = OUT_TDATA_BITS - ACC_BITS - COL_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_ROW_WIDTH = 3'd1,
    REG_COEF_0    = 3'd2,
    REG_COEF_1    = 3'd3,
    REG_COEF_2    = 3'd4,
    REG_COEF_3    = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BACK,
    ST_MAC,
    ST_DRAIN
  } state_t;

  // effective (clamped) settings
  typedef struct packed {
    logic [TCNT_BITS-1:0] taps;
    logic [CNT_BITS-1:0]  width;
  } cfg_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

endpackage

// ===== design/rfse_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module rfse_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rfse_cfg.sv =====
// Configuration registers, clamping and coefficient selection
module rfse_cfg (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [rfse_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [rfse_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic [rfse_pkg::TAP_BITS-1:0]             tap_sel,
  output rfse_pkg::cfg_t                            cfg,
  output logic signed [rfse_pkg::COEF_BITS-1:0]     coef
);
  import rfse_pkg::*;

  logic [TCNT_BITS-1:0]      tap_count;
  logic [ROW_WIDTH_BITS-1:0] row_width;
  logic [CFG_DATA_BITS-1:0]  coef_word [COEF_WORDS];
  logic [CFG_DATA_BITS-1:0]  word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TCNT_BITS'(13);
      row_width <= ROW_WIDTH_BITS'(1280);
      for (int i = 0; i < COEF_WORDS; i++) begin
        coef_word[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count    <= cfg_data[TCNT_BITS-1:0];
        REG_ROW_WIDTH: row_width    <= cfg_data[ROW_WIDTH_BITS-1:0];
        REG_COEF_0:    coef_word[0] <= cfg_data;
        REG_COEF_1:    coef_word[1] <= cfg_data;
        REG_COEF_2:    coef_word[2] <= cfg_data;
        REG_COEF_3:    coef_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      cfg.taps = TCNT_BITS'(1);
    end else if (tap_count > TCNT_BITS'(MAX_TAPS)) begin
      cfg.taps = TCNT_BITS'(MAX_TAPS);
    end else begin
      cfg.taps = tap_count;
    end
    if (row_width == '0) begin
      cfg.width = CNT_BITS'(1);
    end else if (row_width > ROW_WIDTH_BITS'(MAX_WIDTH)) begin
      cfg.width = CNT_BITS'(MAX_WIDTH);
    end else begin
      cfg.width = CNT_BITS'(row_width);
    end
  end

  // four 16-bit slots per word, lowest tap in the low slot
  assign word = coef_word[tap_sel[TAP_BITS-1 -: WORD_SEL_BITS]];
  assign coef = $signed(word[tap_sel[WORD_SEL_BITS-1:0] * COEF_SLOT +: COEF_BITS]);

endmodule

// ===== design/rfse_mac.sv =====
// Shared multiply-accumulate: registered coefficient, product and sum
module rfse_mac (
  input  logic                                      clk,
  input  logic                                      rst,
  input  rfse_pkg::mac_ctl_t                        ctl,
  input  logic signed [rfse_pkg::COEF_BITS-1:0]     coef,
  input  logic signed [rfse_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                                      busy,
  output logic signed [rfse_pkg::ACC_BITS-1:0]      acc
);
  import rfse_pkg::*;

  logic                         data_v;
  logic                         prod_v;
  logic signed [COEF_BITS-1:0]  coef_q;
  logic signed [PROD_BITS-1:0]  prod;

  // sample arrives from the store in the cycle after issue, beside coef_q
  always_ff @(posedge clk) begin
    if (rst) begin
      data_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      data_v <= ctl.issue;
      prod_v <= data_v;
    end
  end

  always_ff @(posedge clk) begin
    coef_q <= coef;
    if (data_v) begin
      prod <= PROD_BITS'(sample * coef_q);
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(ACC_BITS - PROD_BITS){prod[PROD_BITS-1]}}, prod};
    end
  end

  assign busy = data_v | prod_v;

endmodule

// ===== design/rfse_ctrl.sv =====
// Sequencer: row counters, mirrored index walk, tap loop and result register
module rfse_ctrl (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic signed [rfse_pkg::SAMPLE_BITS-1:0]   pixel,
  input  rfse_pkg::cfg_t                            cfg,
  output logic [rfse_pkg::TAP_BITS-1:0]             tap_sel,
  output rfse_pkg::mac_ctl_t                        mac_ctl,
  input  logic                                      mac_busy,
  input  logic signed [rfse_pkg::ACC_BITS-1:0]      acc,
  output logic                                      ram_we,
  output logic [rfse_pkg::COL_BITS-1:0]             ram_waddr,
  output logic [rfse_pkg::SAMPLE_BITS-1:0]          ram_wdata,
  output logic [rfse_pkg::COL_BITS-1:0]             ram_raddr,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic signed [rfse_pkg::ACC_BITS-1:0]      filtered,
  output logic [rfse_pkg::COL_BITS-1:0]             column,
  output logic                                      last_of_run
);
  import rfse_pkg::*;

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   ic, ic_next;
  logic [CNT_BITS-1:0]   oc, oc_next;
  logic                  row_end, row_end_next;
  logic [RES_BITS-1:0]   cnt, cnt_next;
  logic [COL_BITS-1:0]   p, p_next;
  logic                  dir, dir_next;
  logic [TAP_BITS-1:0]   step_cnt, step_cnt_next;
  logic                  out_valid, out_valid_next;
  logic                  load;

  logic [TCNT_BITS-1:0]  off;
  logic [TCNT_BITS-1:0]  lead;
  logic [COL_BITS-1:0]   wm1;
  logic [CNT_BITS-1:0]   ic_inc;
  logic [CNT_BITS-1:0]   oc_inc;
  logic [RES_BITS-1:0]   cnt_inc;
  logic [CNT_BITS:0]     reach_now;
  logic [CNT_BITS:0]     reach_next;
  logic                  due_now;
  logic                  due_next;
  logic [COL_BITS-1:0]   fwd_p, back_p;
  logic                  fwd_dir, back_dir;

  assign off     = (cfg.taps - TCNT_BITS'(1)) >> 1;
  assign lead    = cfg.taps - off;
  assign wm1     = COL_BITS'(cfg.width - CNT_BITS'(1));
  assign ic_inc  = ic + CNT_BITS'(1);
  assign oc_inc  = oc + CNT_BITS'(1);
  assign cnt_inc = cnt + RES_BITS'(1);

  // a column is due once its rightmost tap has arrived, or at row end
  assign reach_now  = {1'b0, oc} + (CNT_BITS + 1)'(lead);
  assign reach_next = {1'b0, oc_inc} + (CNT_BITS + 1)'(lead);
  assign due_now  = (cnt < RES_BITS'(MAX_RESULTS)) && (oc < cfg.width) &&
                    (row_end || reach_now <= {1'b0, ic});
  assign due_next = (cnt_inc < RES_BITS'(MAX_RESULTS)) && (oc_inc < cfg.width) &&
                    (row_end || reach_next <= {1'b0, ic});

  // mirrored walk, edge sample repeated; dir high = index rising going right
  always_comb begin
    if (dir) begin
      fwd_p    = (p == wm1) ? p : p + COL_BITS'(1);
      fwd_dir  = (p != wm1);
      back_p   = (p == '0) ? p : p - COL_BITS'(1);
      back_dir = (p != '0);
    end else begin
      fwd_p    = (p == '0) ? p : p - COL_BITS'(1);
      fwd_dir  = (p == '0);
      back_p   = (p == wm1) ? p : p + COL_BITS'(1);
      back_dir = (p == wm1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ic        <= '0;
      oc        <= '0;
      row_end   <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ic        <= ic_next;
      oc        <= oc_next;
      row_end   <= row_end_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p        <= p_next;
    dir      <= dir_next;
    step_cnt <= step_cnt_next;
    if (load) begin
      filtered    <= acc;
      column      <= oc[COL_BITS-1:0];
      last_of_run <= !due_next;
    end
  end

  always_comb begin
    state_next    = state;
    ic_next       = ic;
    oc_next       = oc;
    row_end_next  = row_end;
    cnt_next      = cnt;
    p_next        = p;
    dir_next      = dir;
    step_cnt_next = step_cnt;
    load          = 1'b0;
    mac_ctl       = '0;
    ram_we        = 1'b0;
    ram_waddr     = ic[COL_BITS-1:0];
    ram_wdata     = pixel;
    ram_raddr     = p;
    tap_sel       = step_cnt;
    s_tready      = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ram_we       = 1'b1;
          ic_next      = ic_inc;
          row_end_next = (ic_inc >= cfg.width);
          cnt_next     = '0;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (due_now) begin
          mac_ctl.clear = 1'b1;
          p_next        = oc[COL_BITS-1:0];
          dir_next      = 1'b1;
          if (off != '0) begin
            step_cnt_next = TAP_BITS'(off - TCNT_BITS'(1));
            state_next    = ST_BACK;
          end else begin
            step_cnt_next = TAP_BITS'(cfg.taps - TCNT_BITS'(1));
            state_next    = ST_MAC;
          end
        end else begin
          if (row_end) begin
            ic_next = '0;
            oc_next = '0;
          end
          state_next = ST_IDLE;
        end
      end
      ST_BACK: begin
        // walk left to the column's first tap
        p_next   = back_p;
        dir_next = back_dir;
        if (step_cnt == '0) begin
          step_cnt_next = TAP_BITS'(cfg.taps - TCNT_BITS'(1));
          state_next    = ST_MAC;
        end else begin
          step_cnt_next = step_cnt - TAP_BITS'(1);
        end
      end
      ST_MAC: begin
        // taps read left to right against coefficients high to low
        mac_ctl.issue = 1'b1;
        p_next        = fwd_p;
        dir_next      = fwd_dir;
        if (step_cnt == '0) begin
          state_next = ST_DRAIN;
        end else begin
          step_cnt_next = step_cnt - TAP_BITS'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && (!out_valid || m_tready)) begin
          load     = 1'b1;
          oc_next  = oc_inc;
          cnt_next = cnt_inc;
          if (due_next) begin
            state_next = ST_CHECK;
          end else begin
            if (row_end) begin
              ic_next = '0;
              oc_next = '0;
            end
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid);
  assign m_tvalid       = out_valid;

endmodule

// ===== design/row_fir_symmetric_extension.sv =====
// Top level: row FIR with mirrored edges over a shared multiply-accumulate
// A pixel releases up to nine columns (none if no column is due); each column takes a walk back over
// (T-1)/2 taps (T = taps in use), a MAC pass over the T taps and a drain that also waits
// for the previous result to leave the output register.
// One pixel at a time, set by the single MAC stepping one tap per cycle; a result
// sits in an output register, so the next pixel is taken meanwhile. rst (synchronous)
// clears counters, sequencer and config registers to defaults; the row store is not cleared.
module row_fir_symmetric_extension (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [rfse_pkg::IN_TDATA_BITS-1:0]        s_tdata,   // [15:0] pixel_in
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [rfse_pkg::OUT_TDATA_BITS-1:0]       m_tdata,   // [35:0] filtered, [46:36] column
  output logic                                      m_tlast,   // last_of_run
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [rfse_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [rfse_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import rfse_pkg::*;

  cfg_t                         cfg;
  mac_ctl_t                     mac_ctl;
  logic [TAP_BITS-1:0]          tap_sel;
  logic signed [COEF_BITS-1:0]  coef;
  logic                         mac_busy;
  logic signed [ACC_BITS-1:0]   acc;
  logic                         ram_we;
  logic [COL_BITS-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0]       ram_wdata;
  logic [COL_BITS-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0]       ram_rdata;
  logic signed [ACC_BITS-1:0]   filtered;
  logic [COL_BITS-1:0]          column;

  rfse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tap_sel   (tap_sel),
    .cfg       (cfg),
    .coef      (coef)
  );

  rfse_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfse_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .coef   (coef),
    .sample ($signed(ram_rdata)),
    .busy   (mac_busy),
    .acc    (acc)
  );

  rfse_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .pixel       ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .cfg         (cfg),
    .tap_sel     (tap_sel),
    .mac_ctl     (mac_ctl),
    .mac_busy    (mac_busy),
    .acc         (acc),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .filtered    (filtered),
    .column      (column),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {{OUT_PAD_BITS{1'b0}}, column, filtered};

endmodule

// ===== design/rfse_checker.sv =====
// Port-level checks on the row FIR, bound to the top level
module rfse_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [rfse_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input logic                                 m_tlast
);

  // a held result word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // one pixel at a time: busy straight after taking a word
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // more results of this pixel to come, so no new pixel yet
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready with a run still open");

  // results only come out of the sequencer, never from idle
  a_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind row_fir_symmetric_extension rfse_checker u_rfse_checker (.*);
